/* hw/rtl/sk_pkg.sv */
// Shared types and constants for the sorted key list.
`timescale 1ns / 1ps
package sk_pkg;

   // Operation codes carried in the request mode field
   localparam logic [2:0] MODE_INSERT    = 3'd0;
   localparam logic [2:0] MODE_RM_FIRST  = 3'd1;
   localparam logic [2:0] MODE_RM_LAST   = 3'd2;
   localparam logic [2:0] MODE_RM_KEY    = 3'd3;
   localparam logic [2:0] MODE_LOOKUP    = 3'd4;
   localparam logic [2:0] MODE_CLEAR     = 3'd5;

   localparam int KEY_W = 32;
   localparam int POS_W = 6;
   localparam int CNT_OUT_W = 7;

   typedef struct packed {
      logic [2:0]              mode;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic [POS_W-1:0]        position;
      logic signed [KEY_W-1:0] removed_key;
      logic [CNT_OUT_W-1:0]    count;
      logic                    full_res;
      logic                    empty_res;
   } rsp_type;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic cmp_en;   // latch compare flags against the request key
      logic ins_en;   // ordered insert
      logic pop_en;   // shift everything one slot toward the head
      logic rmk_en;   // close the gap at the first matching slot
   } cell_ctl_type;

   // Compare flags a cell shares with its neighbors
   typedef struct packed {
      logic occ;
      logic le;
      logic match;
   } cell_flag_type;

   // One-hot markers a cell raises for the slot selector
   typedef struct packed {
      logic ins_slot;
      logic first;
      logic last;
   } cell_hit_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

endpackage

/* hw/rtl/sk_cell.sv */
// One slot of the sorted list: holds a key, compares and shifts with its neighbors.
`timescale 1ns / 1ps
module sk_cell #(
   parameter int CNT_W = 7,
   parameter int SLOT  = 0
) (
   input  logic                           clock,
   input  sk_pkg::cell_ctl_type           ctl,
   input  logic signed [sk_pkg::KEY_W-1:0] key,
   input  logic [CNT_W-1:0]               count,
   input  logic signed [sk_pkg::KEY_W-1:0] left_key,
   input  logic signed [sk_pkg::KEY_W-1:0] right_key,
   input  sk_pkg::cell_flag_type          prev_flag,
   input  sk_pkg::cell_flag_type          next_flag,
   output logic signed [sk_pkg::KEY_W-1:0] entry,
   output sk_pkg::cell_flag_type          flag,
   output sk_pkg::cell_hit_type           hit
);
   import sk_pkg::*;

   logic signed [KEY_W-1:0] entry_ff, entry_in;
   cell_flag_type           flag_ff;
   logic                    lt_ff;
   logic                    occ_now;

   assign occ_now = (CNT_W'(SLOT) < count);

   // Compare flags latched when a request is taken
   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         flag_ff.occ   <= occ_now;
         flag_ff.le    <= occ_now && (entry_ff <= key);
         flag_ff.match <= occ_now && (entry_ff == key);
         lt_ff         <= occ_now && (entry_ff < key);
      end
   end

   // Next key: keep, take the new key, or take a neighbor's key
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en) begin
         if (flag_ff.le) begin
            entry_in = entry_ff;
         end else if (prev_flag.le) begin
            entry_in = key;
         end else begin
            entry_in = left_key;
         end
      end else if (ctl.pop_en) begin
         entry_in = right_key;
      end else if (ctl.rmk_en && !lt_ff) begin
         entry_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry        = entry_ff;
   assign flag         = flag_ff;
   assign hit.ins_slot = prev_flag.le && !flag_ff.le;
   assign hit.first    = flag_ff.match && !prev_flag.match;
   assign hit.last     = flag_ff.occ && !next_flag.occ;

endmodule

/* hw/rtl/sk_sel.sv */
// One-hot slot selector: encodes the marked slot and picks its key.
`timescale 1ns / 1ps
module sk_sel #(
   parameter int CAPACITY = 64
) (
   input  logic [CAPACITY-1:0]             onehot,
   input  logic signed [sk_pkg::KEY_W-1:0] keys [CAPACITY],
   output logic [$clog2(CAPACITY)-1:0]     idx,
   output logic signed [sk_pkg::KEY_W-1:0] key
);
   import sk_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   // AND-OR reduction across the row
   always_comb begin
      idx = '0;
      key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (onehot[i]) begin
            idx = idx | IDX_W'(i);
            key = key | keys[i];
         end
      end
   end

endmodule

/* hw/rtl/sorted_key_list_top.sv */
// Top level of the sorted key list: request sequencer, cell row and response register.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | sk_pkg::req_type (mode, key)
//   rsp_    | out       | rsp_valid / rsp_ready | sk_pkg::rsp_type
//
// For each request, the accept edge latches the compare flags in every cell; a
// later edge, in ST_APPLY, shifts the row and loads the response register.
// A new request is taken once the row has been updated, while the previous
// response may still be waiting. If a response is still pending when the
// next one is due, the update waits until rsp_ready. Reset is synchronous, holds
// req_ready low and clears the count and handshake state; stored keys are not cleared.
`timescale 1ns / 1ps
module sorted_key_list_top #(
   parameter int CAPACITY = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  sk_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output sk_pkg::rsp_type rsp_data
);
   import sk_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   state_type              state_ff, state_in;
   req_type                req_ff;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                   req_take;
   logic                   commit;
   cell_ctl_type           ctl;
   logic signed [KEY_W-1:0] cell_key;

   logic signed [KEY_W-1:0] entry [CAPACITY];
   cell_flag_type           flag [CAPACITY];
   cell_hit_type            hit [CAPACITY];
   logic [CAPACITY-1:0]     ins_vec, first_vec, last_vec, sel_vec;

   logic [IDX_W-1:0]        sel_idx;
   logic signed [KEY_W-1:0] sel_key;

   logic                    full, empty, found;
   logic                    ok;
   logic [IDX_W-1:0]        pos_idx;
   logic signed [KEY_W-1:0] removed;
   logic [IDX_W+POS_W-1:0]  pos_ext;
   logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

   // Handshake and sequencing
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign req_take  = req_valid && req_ready;
   assign commit    = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);
   assign found = |first_vec;

   // Broadcast control to the cell row
   assign cell_key   = req_take ? req_data.key : req_ff.key;
   assign ctl.cmp_en = req_take;
   assign ctl.ins_en = commit && (req_ff.mode == MODE_INSERT) && !full;
   assign ctl.pop_en = commit && (req_ff.mode == MODE_RM_FIRST) && !empty;
   assign ctl.rmk_en = commit && (req_ff.mode == MODE_RM_KEY) && found;

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_flag_type           prev_flag, next_flag;
      logic signed [KEY_W-1:0] left_key, right_key;

      if (i == 0) begin : g_head
         assign prev_flag = '{occ: 1'b1, le: 1'b1, match: 1'b0};
         assign left_key  = '0;
      end else begin : g_body
         assign prev_flag = flag[i-1];
         assign left_key  = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_flag = '0;
         assign right_key = '0;
      end else begin : g_mid
         assign next_flag = flag[i+1];
         assign right_key = entry[i+1];
      end

      sk_cell #(
         .CNT_W (CNT_W),
         .SLOT  (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .key       (cell_key),
         .count     (count_ff),
         .left_key  (left_key),
         .right_key (right_key),
         .prev_flag (prev_flag),
         .next_flag (next_flag),
         .entry     (entry[i]),
         .flag      (flag[i]),
         .hit       (hit[i])
      );

      assign ins_vec[i]   = hit[i].ins_slot;
      assign first_vec[i] = hit[i].first;
      assign last_vec[i]  = hit[i].last;
   end

   // Pick the marker row that the operation needs
   always_comb begin
      case (req_ff.mode)
         MODE_INSERT:  sel_vec = ins_vec;
         MODE_RM_LAST: sel_vec = last_vec;
         MODE_RM_KEY:  sel_vec = first_vec;
         MODE_LOOKUP:  sel_vec = first_vec;
         default:      sel_vec = '0;
      endcase
   end

   sk_sel #(
      .CAPACITY (CAPACITY)
   ) u_sel (
      .onehot (sel_vec),
      .keys   (entry),
      .idx    (sel_idx),
      .key    (sel_key)
   );

   // Result and count update
   always_comb begin
      ok       = 1'b0;
      pos_idx  = '0;
      removed  = '0;
      count_in = count_ff;
      case (req_ff.mode)
         MODE_INSERT: begin
            if (!full) begin
               ok      = 1'b1;
               pos_idx = sel_idx;
            end
         end
         MODE_RM_FIRST: begin
            if (!empty) begin
               ok      = 1'b1;
               removed = entry[0];
            end
         end
         MODE_RM_LAST: begin
            if (!empty) begin
               ok      = 1'b1;
               pos_idx = sel_idx;
               removed = sel_key;
            end
         end
         MODE_RM_KEY: begin
            if (found) begin
               ok      = 1'b1;
               pos_idx = sel_idx;
               removed = sel_key;
            end
         end
         MODE_LOOKUP: begin
            if (found) begin
               ok      = 1'b1;
               pos_idx = sel_idx;
            end
         end
         MODE_CLEAR: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      if (commit) begin
         case (req_ff.mode)
            MODE_INSERT: begin
               if (!full) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            MODE_RM_FIRST, MODE_RM_LAST: begin
               if (!empty) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            MODE_RM_KEY: begin
               if (found) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            MODE_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   assign pos_ext = {{POS_W{1'b0}}, pos_idx};
   assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_in};

   always_comb begin
      rsp_in.ok          = ok;
      rsp_in.position    = pos_ext[POS_W-1:0];
      rsp_in.removed_key = removed;
      rsp_in.count       = cnt_ext[CNT_OUT_W-1:0];
      rsp_in.full_res    = (count_in == CNT_W'(CAPACITY));
      rsp_in.empty_res   = (count_in == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the sorted key list: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_top;
   import sk_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 600;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 300000;

   // Mode codes the block must treat as no-ops
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic [2:0]              mode;
      logic signed [KEY_W-1:0] key;
      bit                      typed;   // want holds a hand-written response
      rsp_type                 want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic signed [KEY_W-1:0] shadow_keys[$];   // predicted list contents, ascending
   rsp_type                 pending_rsp[$];   // expected responses, oldest first
   int err_count = 0;
   int req_sent = 0;
   int burst_left = 0;
   int cycle_cnt = 0;
   int stall_asks = 0;
   int stall_seen = 0;
   int hold_left = 0;
   int seg_left = 0;
   int seg_kind = 0;

   sorted_key_list_top #(.CAPACITY(CAPACITY)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one request to the shadow list and return the response it should give
   function automatic rsp_type list_apply(input req_type r);
      rsp_type res;
      int slot;
      logic signed [KEY_W-1:0] k;
      res = '0;
      k = r.key;
      slot = 0;
      case (r.mode)
         MODE_INSERT: begin
            if (shadow_keys.size() < CAPACITY) begin
               // equal keys stay ahead of the new one
               slot = shadow_keys.size();
               while (slot > 0 && k < shadow_keys[slot-1]) slot--;
               shadow_keys.insert(slot, k);
               res.ok = 1'b1;
               res.position = POS_W'(slot);
            end
         end
         MODE_RM_FIRST: begin
            if (shadow_keys.size() > 0) begin
               res.removed_key = shadow_keys.pop_front();
               res.ok = 1'b1;
            end
         end
         MODE_RM_LAST: begin
            if (shadow_keys.size() > 0) begin
               res.position = POS_W'(shadow_keys.size() - 1);
               res.removed_key = shadow_keys.pop_back();
               res.ok = 1'b1;
            end
         end
         MODE_RM_KEY, MODE_LOOKUP: begin
            // lowest matching slot wins
            while (slot < shadow_keys.size() && shadow_keys[slot] != k) slot++;
            if (slot < shadow_keys.size()) begin
               res.ok = 1'b1;
               res.position = POS_W'(slot);
               if (r.mode == MODE_RM_KEY) begin
                  res.removed_key = shadow_keys[slot];
                  shadow_keys.delete(slot);
               end
            end
         end
         MODE_CLEAR: begin
            shadow_keys.delete();
            res.ok = 1'b1;
         end
         default: ;
      endcase
      res.count = CNT_OUT_W'(shadow_keys.size());
      res.full_res = (shadow_keys.size() == CAPACITY);
      res.empty_res = (shadow_keys.size() == 0);
      return res;
   endfunction

   // Row checked against the shadow list
   function automatic stim_row_type pre(input logic [2:0] mode, input logic signed [31:0] key);
      stim_row_type row;
      row.mode = mode;
      row.key = key;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   // Row with its response written out
   function automatic stim_row_type typ(input logic [2:0] mode, input logic signed [31:0] key,
                                        input bit ok, input int pos, input int cnt,
                                        input bit full, input bit empty);
      stim_row_type row;
      row = pre(mode, key);
      row.typed = 1'b1;
      row.want.ok = ok;
      row.want.position = POS_W'(pos);
      row.want.removed_key = '0;
      row.want.count = CNT_OUT_W'(cnt);
      row.want.full_res = full;
      row.want.empty_res = empty;
      return row;
   endfunction

   // Key mix: stored keys, a small cluster for duplicates, extremes, full range
   function automatic logic signed [31:0] pick_key(input int stored_pct);
      logic signed [31:0] k;
      k = $urandom;
      if (shadow_keys.size() > 0 && $urandom_range(0, 99) < stored_pct) begin
         k = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
      end else begin
         case ($urandom_range(0, 5))
            0, 1: k = $signed($urandom_range(0, 8)) - 4;
            2: begin
               case ($urandom_range(0, 3))
                  0: k = KEY_MIN;
                  1: k = KEY_MAX;
                  2: k = 0;
                  default: k = -1;
               endcase
            end
            default: ;
         endcase
      end
      return k;
   endfunction

   task automatic flag_error(input string what, input longint got_v, input longint want_v);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got_v, want_v);
      err_count++;
   endtask

   // Offer one request, hold it until taken, then log its expected response
   task automatic send_req(input stim_row_type row);
      req_type r;
      rsp_type want;
      r.mode = row.mode;
      r.key = row.key;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = list_apply(r);
      pending_rsp.push_back(row.typed ? row.want : want);
      req_sent++;
      // bursty sender
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Stop sending until every outstanding response has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic send_mixed(input int n);
      int roll;
      repeat (n) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)      send_req(pre(MODE_INSERT, pick_key(20)));
         else if (roll < 45) send_req(pre(MODE_RM_FIRST, $urandom));
         else if (roll < 55) send_req(pre(MODE_RM_LAST, $urandom));
         else if (roll < 70) send_req(pre(MODE_RM_KEY, pick_key(60)));
         else if (roll < 94) send_req(pre(MODE_LOOKUP, pick_key(60)));
         else if (roll < 96) send_req(pre(MODE_CLEAR, $urandom));
         else send_req(pre(roll[0] ? MODE_SPARE_A : MODE_SPARE_B, $urandom));
      end
   endtask

   // Grow to capacity, then push against the full list
   task automatic send_fill();
      while (shadow_keys.size() < CAPACITY) begin
         if ($urandom_range(0, 9) == 0) send_req(pre(MODE_LOOKUP, pick_key(70)));
         else send_req(pre(MODE_INSERT, pick_key(10)));
      end
      send_req(pre(MODE_LOOKUP, pick_key(80)));
      repeat (3) send_req(pre(MODE_INSERT, pick_key(30)));
   endtask

   // Empty the list by removals, then remove from the empty list
   task automatic send_drain();
      while (shadow_keys.size() > 0) begin
         case ($urandom_range(0, 2))
            0: send_req(pre(MODE_RM_FIRST, $urandom));
            1: send_req(pre(MODE_RM_LAST, $urandom));
            default: send_req(pre(MODE_RM_KEY, pick_key(100)));
         endcase
      end
      send_req(pre(MODE_RM_FIRST, $urandom));
      send_req(pre(MODE_RM_LAST, $urandom));
      send_req(pre(MODE_RM_KEY, $urandom));
   endtask

   // Stimulus
   initial begin : stimulus
      stim_row_type dir_tab[$];
      int round_no;
      // empty list: every removal and lookup fails, spare modes do nothing
      dir_tab.push_back(typ(MODE_RM_FIRST, 0, 0, 0, 0, 0, 1));
      dir_tab.push_back(typ(MODE_RM_LAST, 0, 0, 0, 0, 0, 1));
      dir_tab.push_back(typ(MODE_RM_KEY, 5, 0, 0, 0, 0, 1));
      dir_tab.push_back(typ(MODE_LOOKUP, 0, 0, 0, 0, 0, 1));
      dir_tab.push_back(typ(MODE_SPARE_A, -1, 0, 0, 0, 0, 1));
      dir_tab.push_back(typ(MODE_CLEAR, 0, 1, 0, 0, 0, 1));
      // extremes: max first, then min lands ahead of it
      dir_tab.push_back(typ(MODE_INSERT, KEY_MAX, 1, 0, 1, 0, 0));
      dir_tab.push_back(typ(MODE_INSERT, KEY_MIN, 1, 0, 2, 0, 0));
      dir_tab.push_back(typ(MODE_SPARE_B, KEY_MAX, 0, 0, 2, 0, 0));
      // duplicates go after their equals; lookups find the lowest slot
      dir_tab.push_back(pre(MODE_INSERT, 0));
      dir_tab.push_back(pre(MODE_INSERT, 0));
      dir_tab.push_back(pre(MODE_INSERT, -1));
      dir_tab.push_back(pre(MODE_INSERT, KEY_MAX));
      dir_tab.push_back(pre(MODE_LOOKUP, 0));
      dir_tab.push_back(pre(MODE_LOOKUP, 7));
      dir_tab.push_back(pre(MODE_RM_KEY, 0));
      dir_tab.push_back(pre(MODE_RM_KEY, 7));
      dir_tab.push_back(pre(MODE_LOOKUP, KEY_MAX));
      dir_tab.push_back(pre(MODE_RM_FIRST, 0));
      dir_tab.push_back(pre(MODE_RM_LAST, 0));
      dir_tab.push_back(pre(MODE_INSERT, 32'sh5555_5555));
      dir_tab.push_back(pre(MODE_INSERT, 32'shAAAA_AAAA));
      dir_tab.push_back(typ(MODE_CLEAR, -1, 1, 0, 0, 0, 1));
      dir_tab.push_back(typ(MODE_LOOKUP, 0, 0, 0, 0, 0, 1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_tab[i]) send_req(dir_tab[i]);

      // random rounds: mixed, fill to full, mixed after a drain-out, remove to empty
      round_no = 0;
      while (req_sent < dir_tab.size() + RANDOM_ITEMS) begin
         case (round_no % 4)
            0: send_mixed(40);
            1: begin
               if (round_no < 8) stall_asks <= stall_asks + 1;
               send_fill();
            end
            2: begin
               settle();
               send_mixed(40);
            end
            default: send_drain();
         endcase
         round_no++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   // Response sink: random stall segments, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_seen != stall_asks) begin
         stall_seen <= stall_asks;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_kind <= $urandom_range(0, 3);
            seg_left <= $urandom_range(4, 40);
         end else begin
            seg_left <= seg_left - 1;
         end
         case (seg_kind)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Response check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            flag_error("response with nothing outstanding, count", rsp_data.count, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.ok !== want.ok) flag_error("ok", rsp_data.ok, want.ok);
            if (rsp_data.position !== want.position)
               flag_error("position", rsp_data.position, want.position);
            if (rsp_data.removed_key !== want.removed_key)
               flag_error("removed_key", rsp_data.removed_key, want.removed_key);
            if (rsp_data.count !== want.count) flag_error("count", rsp_data.count, want.count);
            if (rsp_data.full_res !== want.full_res)
               flag_error("full_res", rsp_data.full_res, want.full_res);
            if (rsp_data.empty_res !== want.empty_res)
               flag_error("empty_res", rsp_data.empty_res, want.empty_res);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule

/* files.f */
hw/rtl/sk_pkg.sv
hw/rtl/sk_cell.sv
hw/rtl/sk_sel.sv
hw/rtl/sorted_key_list_top.sv
test/tb_top.sv
